// ===== rtl/touch_zone_key_trigger_defines.svh =====
// Assertion macros used by the RTL module touch_zone_key_trigger.
`ifndef TOUCH_ZONE_KEY_TRIGGER_DEFINES_SVH
`define TOUCH_ZONE_KEY_TRIGGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TZKT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("touch_zone_key_trigger: assertion failed");
`define TZKT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("touch_zone_key_trigger: assertion failed");
`else
`define TZKT_ASSERT(label, prop)
`define TZKT_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/tzkt_pkg.sv =====
package tzkt_pkg;

   localparam int ADC_BITS          = 12;
   localparam int SAMPLES_PER_POINT = 5;
   localparam int CNT_W             = $clog2(SAMPLES_PER_POINT + 1);
   localparam int SUM_W             = ADC_BITS + CNT_W;
   localparam int SIZE_W            = 11;
   localparam int PIX_W             = 10;
   localparam int DEB_W             = 16;
   localparam int DIV_W             = ADC_BITS + PIX_W;
   localparam int DIV_CNT_W         = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 16;
   localparam int ZONE_W            = 2;
   localparam int BYTE_W            = 8;

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(1 << PIX_W);

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_STATUS = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_CAL_MIN      = 3'd0,
      CSR_X_CAL_MAX      = 3'd1,
      CSR_Y_CAL_MIN      = 3'd2,
      CSR_Y_CAL_MAX      = 3'd3,
      CSR_SCREEN_WIDTH   = 3'd4,
      CSR_SCREEN_HEIGHT  = 3'd5,
      CSR_DEBOUNCE_TICKS = 3'd6
   } csr_index_type;

   localparam logic [ZONE_W-1:0] ZONE_TOP = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_MID = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_BOT = 2'd2;

   localparam logic [BYTE_W-1:0] KEY_TOP      = 8'h1B;
   localparam logic [BYTE_W-1:0] KEY_MID      = 8'h19;
   localparam logic [BYTE_W-1:0] KEY_BOT      = 8'h06;
   localparam logic [BYTE_W-1:0] MOD_LEFT_GUI = 8'h08;

   localparam logic [ADC_BITS-1:0] CAL_MIN_RESET  = 12'd350;
   localparam logic [ADC_BITS-1:0] CAL_MAX_RESET  = 12'd3800;
   localparam logic [SIZE_W-1:0]   WIDTH_RESET    = 11'd320;
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET   = 11'd240;
   localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = 16'd260;

   // Last pixel index for a programmed screen size, with the size limited to 1..1024.
   function automatic logic [PIX_W-1:0] size_last(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] eff;
      if (size == '0) begin
         eff = SIZE_W'(1);
      end else if (size > MAX_SIZE) begin
         eff = MAX_SIZE;
      end else begin
         eff = size;
      end
      return PIX_W'(eff - SIZE_W'(1));
   endfunction

endpackage

// ===== rtl/tzkt_if.sv =====
interface tzkt_req_if;
   import tzkt_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic                pen_down;
   logic [ADC_BITS-1:0] sample_x;
   logic [ADC_BITS-1:0] sample_y;
   logic                link_up;

   modport source (output valid, action, pen_down, sample_x, sample_y, link_up,
                   input ready);
   modport sink (input valid, action, pen_down, sample_x, sample_y, link_up,
                 output ready);
endinterface

interface tzkt_rsp_if;
   import tzkt_pkg::*;
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] avg_x;
   logic [ADC_BITS-1:0] avg_y;
   logic [PIX_W-1:0]    screen_x;
   logic [PIX_W-1:0]    screen_y;
   logic [ZONE_W-1:0]   zone;
   logic [BYTE_W-1:0]   key_code;
   logic [BYTE_W-1:0]   modifier_bits;
   logic                report_sent;

   modport source (output valid, avg_x, avg_y, screen_x, screen_y, zone, key_code,
                   modifier_bits, report_sent, input ready);
   modport sink (input valid, avg_x, avg_y, screen_x, screen_y, zone, key_code,
                 modifier_bits, report_sent, output ready);
endinterface

interface tzkt_csr_if;
   import tzkt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/touch_zone_key_trigger.sv =====
// Ticks, link status events and sample pairs that do not end a burst are handled in the idle
// state without leaving it. A pair that ends an accepted burst takes two reciprocal-multiply
// steps for the averages, then per axis a clamp, a multiply and 22 restoring divide steps
// (a clamped axis skips multiply and divide), with input held off until the result is registered
// and for as long as the previous result still waits. Synchronous active-high reset restores
// the calibration defaults, clears burst, ticks, release flag and link, and drops any result.
`include "touch_zone_key_trigger_defines.svh"

module touch_zone_key_trigger (
   input  logic clock,
   input  logic reset,
   tzkt_req_if.sink   req_if,
   tzkt_rsp_if.source rsp_if,
   tzkt_csr_if.sink   csr_if
);
   import tzkt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AVG,
      S_CLAMP,
      S_MUL,
      S_DIV,
      S_FIN
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = DIV_CNT_W'(DIV_W);
   localparam logic [CNT_W-1:0]     LAST_COUNT  = CNT_W'(SAMPLES_PER_POINT - 1);
   localparam int                   AVG_SHIFT   = SUM_W + CNT_W;
   localparam int                   AVG_PROD_W  = SUM_W + AVG_SHIFT;
   localparam logic [AVG_SHIFT-1:0] AVG_RECIP   =
      AVG_SHIFT'(((1 << AVG_SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT);

   state_type state_ff, state_in;
   logic axis_ff, axis_in;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [DEB_W-1:0]    elapsed_ff, elapsed_in;
   logic                await_ff, await_in;
   logic                link_ff, link_in;

   logic [ADC_BITS-1:0] x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic [ADC_BITS-1:0] y_min_ff, y_min_in, y_max_ff, y_max_in;
   logic [SIZE_W-1:0]   width_ff, width_in, height_ff, height_in;
   logic [DEB_W-1:0]    debounce_ff, debounce_in;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [ADC_BITS-1:0]  rem_ff, rem_in;
   logic [ADC_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [ADC_BITS-1:0] avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;
   logic [PIX_W-1:0]    px_ff, px_in, py_ff, py_in;
   logic [ADC_BITS-1:0] diff_ff, diff_in, span_ff, span_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADC_BITS-1:0] out_avg_x_ff, out_avg_x_in, out_avg_y_ff, out_avg_y_in;
   logic [PIX_W-1:0]    out_px_ff, out_px_in, out_py_ff, out_py_in;
   logic [ZONE_W-1:0]   out_zone_ff, out_zone_in;
   logic [BYTE_W-1:0]   out_key_ff, out_key_in;
   logic                out_sent_ff, out_sent_in;

   logic [ADC_BITS:0]   rem_sh;
   logic                rem_ge;
   logic [ADC_BITS-1:0] rem_step;
   logic [DIV_W-1:0]    quo_step;

   logic [AVG_PROD_W-1:0] avg_prod;
   logic [ADC_BITS-1:0]   avg_val;

   logic [ADC_BITS-1:0] raw, lo, hi;
   logic [PIX_W-1:0]    last;
   logic                pix_wr;
   logic [PIX_W-1:0]    pix_val;

   logic [PIX_W:0]      py_inc;
   logic [PIX_W+1:0]    py_tri;
   logic [SIZE_W-1:0]   h_eff;
   logic [SIZE_W:0]     h_two;
   logic [ZONE_W-1:0]   zone_val;
   logic [BYTE_W-1:0]   key_val;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.avg_x         = out_avg_x_ff;
   assign rsp_if.avg_y         = out_avg_y_ff;
   assign rsp_if.screen_x      = out_px_ff;
   assign rsp_if.screen_y      = out_py_ff;
   assign rsp_if.zone          = out_zone_ff;
   assign rsp_if.key_code      = out_key_ff;
   assign rsp_if.modifier_bits = MOD_LEFT_GUI;
   assign rsp_if.report_sent   = out_sent_ff;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
      rem_ge   = (rem_sh >= {1'b0, divisor_ff});
      rem_step = rem_ge ? ADC_BITS'(rem_sh - {1'b0, divisor_ff}) : rem_sh[ADC_BITS-1:0];
      quo_step = {quo_ff[DIV_W-2:0], rem_ge};
   end

   always_comb begin
      avg_prod = AVG_PROD_W'(axis_ff ? sum_y_ff : sum_x_ff) * AVG_PROD_W'(AVG_RECIP);
      avg_val  = avg_prod[AVG_SHIFT +: ADC_BITS];
   end

   always_comb begin
      raw  = axis_ff ? avg_y_ff : avg_x_ff;
      lo   = axis_ff ? y_min_ff : x_min_ff;
      hi   = axis_ff ? y_max_ff : x_max_ff;
      last = axis_ff ? size_last(height_ff) : size_last(width_ff);
   end

   always_comb begin
      py_inc = {1'b0, py_ff} + (PIX_W + 1)'(1);
      py_tri = {1'b0, py_inc} + {py_inc, 1'b0};
      h_eff  = {1'b0, size_last(height_ff)} + SIZE_W'(1);
      h_two  = {h_eff, 1'b0};
      if (py_tri <= {1'b0, h_eff}) begin
         zone_val = ZONE_TOP;
         key_val  = KEY_TOP;
      end else if (py_tri <= h_two) begin
         zone_val = ZONE_MID;
         key_val  = KEY_MID;
      end else begin
         zone_val = ZONE_BOT;
         key_val  = KEY_BOT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      elapsed_in   = elapsed_ff;
      await_in     = await_ff;
      link_in      = link_ff;
      x_min_in     = x_min_ff;
      x_max_in     = x_max_ff;
      y_min_in     = y_min_ff;
      y_max_in     = y_max_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      debounce_in  = debounce_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      div_cnt_in   = div_cnt_ff;
      avg_x_in     = avg_x_ff;
      avg_y_in     = avg_y_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      diff_in      = diff_ff;
      span_in      = span_ff;
      rsp_valid_in = rsp_valid_ff;
      out_avg_x_in = out_avg_x_ff;
      out_avg_y_in = out_avg_y_ff;
      out_px_in    = out_px_ff;
      out_py_in    = out_py_ff;
      out_zone_in  = out_zone_ff;
      out_key_in   = out_key_ff;
      out_sent_in  = out_sent_ff;
      pix_wr       = 1'b0;
      pix_val      = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_X_CAL_MIN:      x_min_in    = csr_if.wdata[ADC_BITS-1:0];
            CSR_X_CAL_MAX:      x_max_in    = csr_if.wdata[ADC_BITS-1:0];
            CSR_Y_CAL_MIN:      y_min_in    = csr_if.wdata[ADC_BITS-1:0];
            CSR_Y_CAL_MAX:      y_max_in    = csr_if.wdata[ADC_BITS-1:0];
            CSR_SCREEN_WIDTH:   width_in    = csr_if.wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT:  height_in   = csr_if.wdata[SIZE_W-1:0];
            CSR_DEBOUNCE_TICKS: debounce_in = csr_if.wdata[DEB_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               unique case (req_if.action)
                  ACT_TICK: begin
                     if (elapsed_ff != '1) begin
                        elapsed_in = elapsed_ff + DEB_W'(1);
                     end
                  end
                  ACT_STATUS: link_in = req_if.link_up;
                  ACT_SAMPLE: begin
                     if (cnt_ff == '0 && !req_if.pen_down) begin
                        await_in = 1'b0;
                     end else if (!(cnt_ff == '0 && await_ff)) begin
                        sum_x_in = ((cnt_ff == '0) ? '0 : sum_x_ff) + SUM_W'(req_if.sample_x);
                        sum_y_in = ((cnt_ff == '0) ? '0 : sum_y_ff) + SUM_W'(req_if.sample_y);
                        if (cnt_ff == LAST_COUNT) begin
                           cnt_in = '0;
                           if (elapsed_ff >= debounce_ff) begin
                              elapsed_in = '0;
                              await_in   = 1'b1;
                              axis_in    = 1'b0;
                              state_in   = S_AVG;
                           end
                        end else begin
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_AVG: begin
            if (!axis_ff) begin
               avg_x_in = avg_val;
               axis_in  = 1'b1;
            end else begin
               avg_y_in = avg_val;
               axis_in  = 1'b0;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (raw <= lo) begin
               pix_wr  = 1'b1;
               pix_val = '0;
            end else if (raw >= hi) begin
               pix_wr  = 1'b1;
               pix_val = last;
            end else begin
               diff_in  = raw - lo;
               span_in  = hi - lo;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            quo_in     = DIV_W'(diff_ff) * DIV_W'(last);
            rem_in     = '0;
            divisor_in = span_ff;
            div_cnt_in = DIV_STEPS;
            state_in   = S_DIV;
         end
         S_DIV: begin
            quo_in     = quo_step;
            rem_in     = rem_step;
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               pix_wr  = 1'b1;
               pix_val = quo_step[PIX_W-1:0];
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               out_avg_x_in = avg_x_ff;
               out_avg_y_in = avg_y_ff;
               out_px_in    = px_ff;
               out_py_in    = py_ff;
               out_zone_in  = zone_val;
               out_key_in   = key_val;
               out_sent_in  = link_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (pix_wr) begin
         if (!axis_ff) begin
            px_in    = pix_val;
            axis_in  = 1'b1;
            state_in = S_CLAMP;
         end else begin
            py_in    = pix_val;
            axis_in  = 1'b0;
            state_in = S_FIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         elapsed_ff   <= '0;
         await_ff     <= 1'b0;
         link_ff      <= 1'b0;
         x_min_ff     <= CAL_MIN_RESET;
         x_max_ff     <= CAL_MAX_RESET;
         y_min_ff     <= CAL_MIN_RESET;
         y_max_ff     <= CAL_MAX_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         debounce_ff  <= DEBOUNCE_RESET;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         elapsed_ff   <= elapsed_in;
         await_ff     <= await_in;
         link_ff      <= link_in;
         x_min_ff     <= x_min_in;
         x_max_ff     <= x_max_in;
         y_min_ff     <= y_min_in;
         y_max_ff     <= y_max_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         debounce_ff  <= debounce_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_x_ff     <= sum_x_in;
      sum_y_ff     <= sum_y_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      avg_x_ff     <= avg_x_in;
      avg_y_ff     <= avg_y_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      diff_ff      <= diff_in;
      span_ff      <= span_in;
      out_avg_x_ff <= out_avg_x_in;
      out_avg_y_ff <= out_avg_y_in;
      out_px_ff    <= out_px_in;
      out_py_ff    <= out_py_in;
      out_zone_ff  <= out_zone_in;
      out_key_ff   <= out_key_in;
      out_sent_ff  <= out_sent_in;
   end

   `TZKT_ASSERT(a_result_from_fin, $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
   `TZKT_ASSERT(a_count_below_burst, cnt_ff <= LAST_COUNT)
   `TZKT_ASSERT(a_ticks_hold_while_busy, (state_ff != S_IDLE) |=> $stable(elapsed_ff))
   `TZKT_ASSERT(a_divisor_nonzero, (state_ff == S_DIV) |-> (divisor_ff != '0))
   `TZKT_ASSERT(a_zone_matches_key, rsp_valid_ff |->
      ((out_zone_ff == ZONE_TOP && out_key_ff == KEY_TOP) ||
       (out_zone_ff == ZONE_MID && out_key_ff == KEY_MID) ||
       (out_zone_ff == ZONE_BOT && out_key_ff == KEY_BOT)))

endmodule
